### hdl/tpa_pkg.sv
// Shared types and constants of the triangle primitive assembler.
`default_nettype none

package tpa_pkg;

  localparam int unsigned IDX_W = 32;

  // All-ones vertex index: strip restart, or no index held.
  localparam logic [IDX_W-1:0] RESTART_INDEX = {IDX_W{1'b1}};

  // Position within an aligned list group.
  localparam logic [1:0] SLOT_FIRST  = 2'd0;
  localparam logic [1:0] SLOT_SECOND = 2'd1;
  localparam logic [1:0] SLOT_THIRD  = 2'd2;

  // Reset value of the mode register: strip assembly.
  localparam logic STRIP_MODE_RESET = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] vertex_index;
    logic             last_of_run;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] corner_first;
    logic [IDX_W-1:0] corner_second;
    logic [IDX_W-1:0] corner_third;
  } out_item_t;

endpackage : tpa_pkg

`default_nettype wire

### hdl/tpa_in_reg.sv
// Input register of the triangle primitive assembler.
`default_nettype none

module tpa_in_reg
  import tpa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  input  wire logic     step,
  output logic          held_valid,
  output in_item_t      held_item
);

  logic     held_valid_r;
  logic     held_valid_nxt;
  in_item_t held_item_r;

  // Take a new item when empty or when the held one is consumed this cycle.
  assign in_ready = !held_valid_r || step;

  always_comb begin
    held_valid_nxt = held_valid_r;
    if (in_ready) begin
      held_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
    end else begin
      held_valid_r <= held_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item_r <= in_item;
    end
  end

  assign held_valid = held_valid_r;
  assign held_item  = held_item_r;

endmodule : tpa_in_reg

`default_nettype wire

### hdl/tpa_assemble.sv
// Assembly state, mode register and triangle forming logic.
`default_nettype none

module tpa_assemble
  import tpa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cfg_wr_en,
  input  wire logic     cfg_wr_data,
  input  wire logic     step,
  input  wire in_item_t item,
  output logic          tri_valid,
  output out_item_t     tri_item
);

  logic             strip_mode_r;
  logic [IDX_W-1:0] older_index_r;
  logic [IDX_W-1:0] older_index_nxt;
  logic [IDX_W-1:0] newer_index_r;
  logic [IDX_W-1:0] newer_index_nxt;
  logic             strip_parity_r;
  logic             strip_parity_nxt;
  logic [1:0]       group_slot_r;
  logic [1:0]       group_slot_nxt;
  logic             held_ok;
  logic             v_restart;

  assign held_ok   = (older_index_r != RESTART_INDEX) && (newer_index_r != RESTART_INDEX);
  assign v_restart = (item.vertex_index == RESTART_INDEX);

  always_comb begin
    older_index_nxt  = older_index_r;
    newer_index_nxt  = newer_index_r;
    strip_parity_nxt = strip_parity_r;
    group_slot_nxt   = group_slot_r;
    tri_valid        = 1'b0;
    tri_item.corner_first  = older_index_r;
    tri_item.corner_second = newer_index_r;
    tri_item.corner_third  = item.vertex_index;

    if (strip_mode_r) begin
      if (v_restart) begin
        older_index_nxt  = RESTART_INDEX;
        newer_index_nxt  = RESTART_INDEX;
        strip_parity_nxt = 1'b0;
      end else begin
        tri_valid = held_ok;
        // Swap the held corners on odd positions to keep the winding.
        if (strip_parity_r) begin
          tri_item.corner_first  = newer_index_r;
          tri_item.corner_second = older_index_r;
        end
        older_index_nxt  = newer_index_r;
        newer_index_nxt  = item.vertex_index;
        strip_parity_nxt = !strip_parity_r;
      end
    end else begin
      case (group_slot_r)
        SLOT_FIRST: begin
          older_index_nxt = item.vertex_index;
          group_slot_nxt  = SLOT_SECOND;
        end
        SLOT_SECOND: begin
          newer_index_nxt = item.vertex_index;
          group_slot_nxt  = SLOT_THIRD;
        end
        SLOT_THIRD: begin
          // Drop a group that holds a restart marker.
          tri_valid       = held_ok && !v_restart;
          older_index_nxt = RESTART_INDEX;
          newer_index_nxt = RESTART_INDEX;
          group_slot_nxt  = SLOT_FIRST;
        end
        default: begin
          older_index_nxt = RESTART_INDEX;
          newer_index_nxt = RESTART_INDEX;
          group_slot_nxt  = SLOT_FIRST;
        end
      endcase
    end

    // End of run: drop any partial group or strip.
    if (item.last_of_run) begin
      older_index_nxt  = RESTART_INDEX;
      newer_index_nxt  = RESTART_INDEX;
      strip_parity_nxt = 1'b0;
      group_slot_nxt   = SLOT_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_mode_r   <= STRIP_MODE_RESET;
      older_index_r  <= RESTART_INDEX;
      newer_index_r  <= RESTART_INDEX;
      strip_parity_r <= 1'b0;
      group_slot_r   <= SLOT_FIRST;
    end else if (cfg_wr_en) begin
      strip_mode_r   <= cfg_wr_data;
      older_index_r  <= RESTART_INDEX;
      newer_index_r  <= RESTART_INDEX;
      strip_parity_r <= 1'b0;
      group_slot_r   <= SLOT_FIRST;
    end else if (step) begin
      older_index_r  <= older_index_nxt;
      newer_index_r  <= newer_index_nxt;
      strip_parity_r <= strip_parity_nxt;
      group_slot_r   <= group_slot_nxt;
    end
  end

  a_strip_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    strip_mode_r |-> (group_slot_r == SLOT_FIRST))
    else $error("group slot moved in strip mode");

  a_list_parity_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !strip_mode_r |-> !strip_parity_r)
    else $error("strip parity moved in list mode");

  a_no_marker_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (step && tri_valid) |-> (tri_item.corner_first != RESTART_INDEX &&
                             tri_item.corner_second != RESTART_INDEX &&
                             tri_item.corner_third != RESTART_INDEX))
    else $error("triangle carries a restart marker");

  a_run_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.last_of_run) |=> (older_index_r == RESTART_INDEX &&
                                    newer_index_r == RESTART_INDEX &&
                                    !strip_parity_r && group_slot_r == SLOT_FIRST))
    else $error("state not cleared after end of run");

endmodule : tpa_assemble

`default_nettype wire

### hdl/tpa_out_reg.sv
// Result register of the triangle primitive assembler.
`default_nettype none

module tpa_out_reg
  import tpa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      held_valid,
  output logic           step,
  input  wire logic      tri_valid,
  input  wire out_item_t tri_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_item_r;

  // Consume the held item when the result slot is free or drains now.
  assign step = held_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = tri_valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && tri_valid) begin
      out_item_r <= tri_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule : tpa_out_reg

`default_nettype wire

### hdl/triangle_primitive_assembler.sv
// Top level of the triangle primitive assembler.
`default_nettype none

// Triangle primitive assembler: unless out_ready stalls it, takes one vertex
// index per cycle and emits at most one triangle (three corner indices) per
// index. With cfg_wr_data = 1 it builds a triangle strip, swapping the first
// two corners on odd positions to keep the winding; the all-ones index
// restarts the strip. With 0 it builds an independent triangle list in
// aligned groups of three, dropping any group that holds the all-ones index.
// last_of_run ends a run: the marked item is processed, then the assembly
// state clears and a partial group is dropped. A mode write also clears the
// state; write it only while the block is idle. Each item is registered in
// the input register and its triangle in the result register; the state
// update sits between those two registers and is a single step, so nothing
// iterates. Items that produce no triangle are simply absorbed. A stalled
// out_ready holds the result register and back-pressures the input once the
// input register is also full.

module triangle_primitive_assembler
  import tpa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cfg_wr_en,
  input  wire logic     cfg_wr_data,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_item
);

  logic      held_valid;
  in_item_t  held_item;
  logic      step;
  logic      tri_valid;
  out_item_t tri_item;

  // Hold the incoming item until the assembly step can take it.
  tpa_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .step       (step),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // Advance strip or list state and form the triangle.
  tpa_assemble u_assemble (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .item        (held_item),
    .tri_valid   (tri_valid),
    .tri_item    (tri_item)
  );

  // Register the triangle and drive the result handshake.
  tpa_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .held_valid (held_valid),
    .step       (step),
    .tri_valid  (tri_valid),
    .tri_item   (tri_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule : triangle_primitive_assembler

`default_nettype wire
